[hdl/sha1he_pkg.sv]
// Shared types and constants of the SHA-1 hash engine.
// Used by the front classifier, the item queue and the compression back end.
`default_nettype none

package sha1he_pkg;

    // One queued item: a message byte and the two flags that travel with it.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_end;
    } sha1he_item_t;

    localparam int unsigned ITEM_W = 10;

    // Initial chaining words h0 to h4.
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one for each group of twenty rounds.
    localparam logic [31:0] K_ROUND [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [2:0] LAST_WORD   = 3'd4;

    // Round groups select the boolean function and the constant.
    typedef enum logic [1:0] {
        GRP_CHOOSE = 2'd0,
        GRP_PARITY = 2'd1,
        GRP_MAJ    = 2'd2,
        GRP_PAR2   = 2'd3
    } sha1he_grp_t;

    // Boolean function of one round.
    function automatic logic [31:0] sha1he_f(
        input sha1he_grp_t grp,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d
    );
        logic [31:0] res;
        case (grp)
            GRP_CHOOSE: res = (b & c) | (~b & d);
            GRP_MAJ:    res = (b & c) | (b & d) | (c & d);
            default:    res = b ^ c ^ d;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[hdl/sha1he_front.sv]
// Input side of the SHA-1 hash engine: accepts items and drops those that
// carry neither a byte nor an end mark. Depends on sha1he_pkg.
`default_nettype none

module sha1he_front (
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  byte_valid,
    input  wire logic                  end_of_message,
    input  wire logic                  q_full,
    output logic                       q_push,
    output sha1he_pkg::sha1he_item_t   q_item
);
    import sha1he_pkg::*;

    // An item is taken whenever the queue has room; only useful items are queued.
    assign full   = q_full;
    assign q_push = push && !q_full && (byte_valid || end_of_message);

    // Pack the fields into a queue entry.
    always_comb
    begin
        q_item.data     = data_byte;
        q_item.has_byte = byte_valid;
        q_item.is_end   = end_of_message;
    end

endmodule

`default_nettype wire

[hdl/sha1he_queue.sv]
// Short item queue between the front classifier and the compression back end.
// Depends on sha1he_pkg for the item type.
`default_nettype none

module sha1he_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire sha1he_pkg::sha1he_item_t wr_item,
    output logic                          full,
    input  wire logic                     rd_en,
    output sha1he_pkg::sha1he_item_t      rd_item,
    output logic                          empty
);
    import sha1he_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sha1he_item_t     store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = store_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_item;
        end
    end

`ifndef SYNTH
    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("queue count beyond depth");
    // With one slot in use and only a read, the queue drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(1) && do_rd && !do_wr) |=> empty)
        else $error("queue did not drain");
    // Read and write pointers meet whenever the queue is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue pointers apart while empty");
`endif

endmodule

`default_nettype wire

[hdl/sha1he_back.sv]
// Compression back end of the SHA-1 hash engine: byte gathering, padding,
// the 80-round compression and digest delivery. Depends on sha1he_pkg.
`default_nettype none

module sha1he_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_empty,
    input  wire sha1he_pkg::sha1he_item_t q_item,
    output logic                          q_pop,
    output logic                          empty,
    input  wire logic                     pop,
    output logic [31:0]                   digest_word,
    output logic [2:0]                    word_index,
    output logic                          last_word
);
    import sha1he_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_OUT
    } state_t;

    state_t       state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [31:0]  h_reg [5];
    logic [31:0]  h_next [5];
    logic [6:0]   rnd_reg, rnd_next;
    logic [2:0]   idx_reg, idx_next;
    logic         end_pend_reg, end_pend_next;
    logic         pad_reg, pad_next;
    logic         pad_first_reg, pad_first_next;
    logic         len_ok_reg, len_ok_next;

    // Payload: 64-byte window that doubles as the message schedule, and the
    // five working words.
    logic [511:0] win_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;

    logic         take_item;
    logic         shift_byte;
    logic [7:0]   byte_in;
    logic [7:0]   pad_byte;
    logic         start_round;
    sha1he_grp_t  grp;
    logic [31:0]  w_head;
    logic [31:0]  w_mix;
    logic [31:0]  w_new;
    logic [31:0]  t_sum;
    logic         out_take;

    // Result side of the queue interface.
    assign empty       = (state_reg != S_OUT);
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_WORD);
    assign out_take    = pop && !empty;

    // Items are drawn from the queue only between blocks.
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign take_item = q_pop;

    // Padding byte: the marker, zeros, then the big-endian bit length.
    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (len_ok_reg && (fill_reg[5:3] == 3'b111))
        begin
            pad_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    assign shift_byte  = (take_item && q_item.has_byte) || (state_reg == S_PAD);
    assign byte_in     = (state_reg == S_PAD) ? pad_byte : q_item.data;
    assign start_round = shift_byte && (fill_reg == 6'd63);

    // Round datapath: one round per cycle.
    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            grp = GRP_CHOOSE;
        end
        else if (rnd_reg < 7'd40)
        begin
            grp = GRP_PARITY;
        end
        else if (rnd_reg < 7'd60)
        begin
            grp = GRP_MAJ;
        end
        else
        begin
            grp = GRP_PAR2;
        end
    end

    assign w_head = win_reg[511:480];
    assign w_mix  = win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416] ^ w_head;
    assign w_new  = {w_mix[30:0], w_mix[31]};
    assign t_sum  = {a_reg[26:0], a_reg[31:27]} + sha1he_f(grp, b_reg, c_reg, d_reg)
                  + e_reg + K_ROUND[grp] + w_head;

    // Control next state.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        rnd_next       = rnd_reg;
        idx_next       = idx_reg;
        end_pend_next  = end_pend_reg;
        pad_next       = pad_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        for (int i = 0; i < 5; i++)
        begin
            h_next[i] = h_reg[i];
        end

        if (shift_byte)
        begin
            fill_next = fill_reg + 6'd1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (take_item)
                begin
                    if (q_item.has_byte)
                    begin
                        bits_next = bits_reg + 64'd8;
                    end
                    if (start_round)
                    begin
                        state_next    = S_ROUND;
                        rnd_next      = '0;
                        end_pend_next = q_item.is_end;
                    end
                    else if (q_item.is_end)
                    begin
                        state_next     = S_PAD;
                        pad_next       = 1'b1;
                        pad_first_next = 1'b1;
                    end
                end
            end
            S_PAD:
            begin
                pad_first_next = 1'b0;
                if (pad_first_reg)
                begin
                    len_ok_next = (fill_reg < 6'd56);
                end
                if (start_round)
                begin
                    state_next = S_ROUND;
                    rnd_next   = '0;
                end
            end
            S_ROUND:
            begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                if (pad_reg)
                begin
                    if (len_ok_reg)
                    begin
                        state_next = S_OUT;
                        idx_next   = '0;
                    end
                    else
                    begin
                        state_next  = S_PAD;
                        len_ok_next = 1'b1;
                    end
                end
                else if (end_pend_reg)
                begin
                    state_next     = S_PAD;
                    pad_next       = 1'b1;
                    pad_first_next = 1'b1;
                    end_pend_next  = 1'b0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_WORD)
                    begin
                        state_next  = S_IDLE;
                        idx_next    = '0;
                        fill_next   = '0;
                        bits_next   = '0;
                        pad_next    = 1'b0;
                        len_ok_next = 1'b0;
                        for (int i = 0; i < 5; i++)
                        begin
                            h_next[i] = H_INIT[i];
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            end_pend_reg  <= 1'b0;
            pad_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            rnd_reg       <= rnd_next;
            idx_reg       <= idx_next;
            end_pend_reg  <= end_pend_next;
            pad_reg       <= pad_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    // Window shifts by a byte while gathering and by a word per round;
    // working words load from the chaining words as a block starts.
    always_ff @(posedge clk)
    begin
        if (shift_byte)
        begin
            win_reg <= {win_reg[503:0], byte_in};
        end
        else if (state_reg == S_ROUND)
        begin
            win_reg <= {win_reg[479:0], w_new};
        end
        if (start_round)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (state_reg == S_ROUND)
        begin
            a_reg <= t_sum;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

`ifndef SYNTH
    // A digest word on offer always has a valid index.
    assert property (@(posedge clk) disable iff (!rst_n) !empty |-> (idx_reg <= LAST_WORD))
        else $error("digest index out of range");
    // Digest delivery starts only at a block boundary.
    assert property (@(posedge clk) disable iff (!rst_n) !empty |-> (fill_reg == '0))
        else $error("digest offered with a partial block");
    // Taking the last word restores the initial chaining value and idles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && last_word) |=> (state_reg == S_IDLE && h_reg[0] == H_INIT[0]
                                     && bits_reg == '0))
        else $error("engine not restarted after digest");
    // The round counter stays within one compression.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (rnd_reg <= LAST_ROUND))
        else $error("round counter overran");
    // Padding only ever follows an end mark.
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == S_PAD) |-> pad_reg)
        else $error("padding without end of message");
`endif

endmodule

`default_nettype wire

[hdl/sha1_hash_engine_core.sv]
// SHA-1 hash engine. Message bytes are pushed one item at a time, an item with
// end_of_message closes the message, and five digest words (h0 first) are popped
// from the result side. Items first land in a short queue; the engine then shifts
// one byte per cycle into its block window while the queue holds items and,
// after 64 bytes, runs one round per cycle. It takes no new bytes while it
// compresses a block; throughput is set by the single round unit and the byte-wide
// fill path. Closing a message adds one padding byte per cycle up to the block end
// plus one or two compressions, and the digest words stay on offer until popped.
// Depends on sha1he_pkg, sha1he_front, sha1he_queue and sha1he_back.
`default_nettype none

module sha1_hash_engine_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        end_of_message,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import sha1he_pkg::*;

    logic         q_full;
    logic         q_push;
    logic         q_empty;
    logic         q_pop;
    sha1he_item_t q_in_item;
    sha1he_item_t q_out_item;

    // Front classifier.
    sha1he_front u_front (
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_in_item)
    );

    // Item queue between the two sides.
    sha1he_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_in_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (q_out_item),
        .empty   (q_empty)
    );

    // Compression back end.
    sha1he_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (q_out_item),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

`default_nettype wire
